// ===== hdl/mshs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mshs_pkg
// shared types and constants of the multiplexed sensor scanner
// ----------------------------------------------------------------------------
package mshs_pkg;

    // request codes of one input beat
    typedef enum logic [1:0] {
        REQ_SAMPLE   = 2'd0,
        REQ_TICK     = 2'd1,
        REQ_WR_HIGH  = 2'd2,
        REQ_WR_LOW   = 2'd3
    } t_req;

    localparam int unsigned CH_PORT_W   = 3;
    localparam int unsigned SAMPLE_W    = 12;
    localparam int unsigned THR_W       = 16;
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned RATE_W      = 23;

    localparam logic [THR_W-1:0]   DEFAULT_HIGH = 16'd1000;
    localparam logic [THR_W-1:0]   DEFAULT_LOW  = 16'd400;
    localparam logic [THR_W-1:0]   THR_MAX      = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;
    localparam logic [RATE_W-1:0]  RATE_MAX     = 23'h7FFFFF;

    // scale of the rate window result
    localparam int unsigned RATE_SCALE = 1000;

endpackage : mshs_pkg
`default_nettype wire

// ===== hdl/mux_sensor_hysteresis_scanner_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mux_sensor_hysteresis_scanner_unit
// light sensor scanner behind an analog mux with per-channel hysteresis
// ----------------------------------------------------------------------------
// The unit takes one request beat per clock cycle unless the output side
// stalls, and returns exactly one result beat per request: the beat is held
// in the input register, then makes one pass through the per-channel register
// tables into the result register. Sustained rate is one beat per cycle while
// the output is not stalled; the limit is the single read/modify/write of the
// channel tables done in the second stage, which also lets a beat see the
// state left by the beat just ahead of it. Sample beats store the raw value
// of the channel on the mux, update its sticky light/dark flag against its
// high and low thresholds, step the mux address with wrap and bump a saturating
// 16-bit scan counter. A rate tick latches count*1000/CHANNELS (saturated to 23
// bits) and clears the counter; the quotient is carried alongside the counter
// as quotient and remainder so that no divider is needed. Threshold writes are
// clamped so high always stays above low. The user must write scan_enable
// through the config port only while the unit is idle; the unit does not enforce it.
// ----------------------------------------------------------------------------
module mux_sensor_hysteresis_scanner_unit #(
    parameter int unsigned CHANNELS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config port
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [11:0] i_sample_value,
    input  wire logic [2:0]  i_target_channel,
    input  wire logic [15:0] i_threshold_value,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_accepted,
    output logic [2:0]       o_channel_out,
    output logic             o_is_light,
    output logic [11:0]      o_raw_out,
    output logic [2:0]       o_mux_address,
    output logic [15:0]      o_high_out,
    output logic [15:0]      o_low_out,
    output logic [22:0]      o_scan_rate
);

    // channel index width follows the table depth
    localparam int unsigned CH_W  = $clog2(CHANNELS);
    // per-sample step of the running quotient count*1000/CHANNELS
    localparam int unsigned Q_STEP = mshs_pkg::RATE_SCALE / CHANNELS;
    localparam int unsigned R_STEP = mshs_pkg::RATE_SCALE % CHANNELS;
    localparam int unsigned Q_MAX  = 65535 * mshs_pkg::RATE_SCALE / CHANNELS;
    localparam int unsigned QW     = $clog2(Q_MAX + 1);
    localparam int unsigned CW     = (QW > mshs_pkg::RATE_W) ? QW : mshs_pkg::RATE_W;

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    logic                              r_scan_enable;
    logic [CH_W-1:0]                   r_cur;
    logic [CHANNELS-1:0]               r_light;
    logic [mshs_pkg::SAMPLE_W-1:0]     r_raw  [CHANNELS];
    logic [mshs_pkg::THR_W-1:0]        r_high [CHANNELS];
    logic [mshs_pkg::THR_W-1:0]        r_low  [CHANNELS];
    logic [mshs_pkg::COUNT_W-1:0]      r_count;
    logic [QW-1:0]                     r_quot;
    logic [CH_W-1:0]                   r_rem;
    logic [mshs_pkg::RATE_W-1:0]       r_rate;

    // input register
    logic                              r_in_valid;
    mshs_pkg::t_req                    r_req;
    logic [mshs_pkg::SAMPLE_W-1:0]     r_sample;
    logic [mshs_pkg::CH_PORT_W-1:0]    r_tch;
    logic [mshs_pkg::THR_W-1:0]        r_thr;

    // result register
    logic                              r_out_valid;
    logic                              r_acc;
    logic [mshs_pkg::CH_PORT_W-1:0]    r_ch_out;
    logic                              r_is_light;
    logic [mshs_pkg::SAMPLE_W-1:0]     r_raw_out;
    logic [mshs_pkg::CH_PORT_W-1:0]    r_mux_out;
    logic [mshs_pkg::THR_W-1:0]        r_high_out;
    logic [mshs_pkg::THR_W-1:0]        r_low_out;

    // handshake
    logic out_ready;
    logic in_ready;
    logic fire;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_ready;
    assign in_ready   = !r_in_valid || out_ready;
    assign o_in_stall = !in_ready;

    // ------------------------------------------------------------------
    // single pass over the channel tables
    // ------------------------------------------------------------------
    logic [mshs_pkg::CH_PORT_W-1:0] rd_ch;
    logic                           ch_ok;
    logic [CH_W-1:0]                idx;
    logic                           n_light_bit;
    logic [mshs_pkg::SAMPLE_W-1:0]  n_raw_val;
    logic [mshs_pkg::THR_W-1:0]     n_high_val;
    logic [mshs_pkg::THR_W-1:0]     n_low_val;
    logic                           tbl_we;
    logic                           n_acc;
    logic [CH_W-1:0]                n_cur;
    logic [mshs_pkg::COUNT_W-1:0]   n_count;
    logic [QW-1:0]                  n_quot;
    logic [CH_W-1:0]                n_rem;
    logic [mshs_pkg::RATE_W-1:0]    n_rate;
    logic [CH_W:0]                  rem_sum;
    logic [CW-1:0]                  quot_ext;

    always_comb begin
        rd_ch       = (r_req == mshs_pkg::REQ_WR_HIGH || r_req == mshs_pkg::REQ_WR_LOW)
                      ? r_tch : mshs_pkg::CH_PORT_W'(r_cur);
        ch_ok       = (32'(rd_ch) < CHANNELS);
        idx         = rd_ch[CH_W-1:0];
        n_light_bit = r_light[idx];
        n_raw_val   = r_raw[idx];
        n_high_val  = r_high[idx];
        n_low_val   = r_low[idx];
        tbl_we      = 1'b0;
        n_acc       = 1'b1;
        n_cur       = r_cur;
        n_count     = r_count;
        n_quot      = r_quot;
        n_rem       = r_rem;
        n_rate      = r_rate;
        rem_sum     = {1'b0, r_rem} + (CH_W + 1)'(R_STEP);
        quot_ext    = CW'(r_quot);

        unique case (r_req)
            mshs_pkg::REQ_SAMPLE: begin
                if (!r_scan_enable) begin
                    n_acc = 1'b0;
                end else begin
                    tbl_we    = 1'b1;
                    n_raw_val = r_sample;
                    if ({4'd0, r_sample} >= r_high[idx]) begin
                        n_light_bit = 1'b1;
                    end else if ({4'd0, r_sample} <= r_low[idx]) begin
                        n_light_bit = 1'b0;
                    end
                    n_cur = (r_cur == CH_W'(CHANNELS - 1)) ? '0 : r_cur + 1'b1;
                    // counter and running quotient move together
                    if (r_count != mshs_pkg::COUNT_MAX) begin
                        n_count = r_count + 1'b1;
                        if (32'(rem_sum) >= CHANNELS) begin
                            n_rem  = CH_W'(32'(rem_sum) - CHANNELS);
                            n_quot = r_quot + QW'(Q_STEP + 1);
                        end else begin
                            n_rem  = rem_sum[CH_W-1:0];
                            n_quot = r_quot + QW'(Q_STEP);
                        end
                    end
                end
            end
            mshs_pkg::REQ_TICK: begin
                n_rate  = (quot_ext > CW'(mshs_pkg::RATE_MAX))
                          ? mshs_pkg::RATE_MAX : quot_ext[mshs_pkg::RATE_W-1:0];
                n_count = '0;
                n_quot  = '0;
                n_rem   = '0;
            end
            mshs_pkg::REQ_WR_HIGH: begin
                if (!ch_ok) begin
                    n_acc = 1'b0;
                end else begin
                    tbl_we = 1'b1;
                    if (r_thr > r_low[idx]) begin
                        n_high_val = r_thr;
                    end else if (r_low[idx] != mshs_pkg::THR_MAX) begin
                        n_high_val = r_low[idx] + 1'b1;
                    end
                end
            end
            mshs_pkg::REQ_WR_LOW: begin
                if (!ch_ok) begin
                    n_acc = 1'b0;
                end else begin
                    tbl_we = 1'b1;
                    if (r_thr < r_high[idx]) begin
                        n_low_val = r_thr;
                    end else if (r_high[idx] != '0) begin
                        n_low_val = r_high[idx] - 1'b1;
                    end
                end
            end
            default: begin
                n_acc = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_enable <= 1'b1;
            r_cur         <= '0;
            r_light       <= '0;
            r_count       <= '0;
            r_quot        <= '0;
            r_rem         <= '0;
            r_rate        <= '0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_raw[i]  <= '0;
                r_high[i] <= mshs_pkg::DEFAULT_HIGH;
                r_low[i]  <= mshs_pkg::DEFAULT_LOW;
            end
        end else begin
            if (i_cfg_we) begin
                r_scan_enable <= i_cfg_wdata;
            end
            if (in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_cur   <= n_cur;
                r_count <= n_count;
                r_quot  <= n_quot;
                r_rem   <= n_rem;
                r_rate  <= n_rate;
                if (tbl_we) begin
                    r_light[idx] <= n_light_bit;
                    r_raw[idx]   <= n_raw_val;
                    r_high[idx]  <= n_high_val;
                    r_low[idx]   <= n_low_val;
                end
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in_valid && in_ready) begin
            r_req    <= mshs_pkg::t_req'(i_req_type);
            r_sample <= i_sample_value;
            r_tch    <= i_target_channel;
            r_thr    <= i_threshold_value;
        end
        if (fire) begin
            r_acc      <= n_acc;
            r_ch_out   <= rd_ch;
            // an out-of-range write reports zeros
            r_is_light <= ch_ok ? n_light_bit : 1'b0;
            r_raw_out  <= ch_ok ? n_raw_val   : '0;
            r_high_out <= ch_ok ? n_high_val  : '0;
            r_low_out  <= ch_ok ? n_low_val   : '0;
            r_mux_out  <= mshs_pkg::CH_PORT_W'(n_cur);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_accepted    = r_acc;
    assign o_channel_out = r_ch_out;
    assign o_is_light    = r_is_light;
    assign o_raw_out     = r_raw_out;
    assign o_mux_address = r_mux_out;
    assign o_high_out    = r_high_out;
    assign o_low_out     = r_low_out;
    // the latch only moves when a beat enters the result register
    assign o_scan_rate   = r_rate;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    logic thr_ordered;

    always_comb begin
        thr_ordered = 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
            if (r_high[i] <= r_low[i]) begin
                thr_ordered = 1'b0;
            end
        end
    end

    a_thr_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        thr_ordered)
        else $error("high threshold not above low threshold");

    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cur) < CHANNELS)
        else $error("mux address out of range");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_rem) < CHANNELS)
        else $error("rate remainder out of range");

    a_tick_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_req == mshs_pkg::REQ_TICK |=> r_count == '0 && r_quot == '0)
        else $error("rate tick did not clear the scan counter");

    a_sample_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_req == mshs_pkg::REQ_SAMPLE && r_scan_enable
        |=> r_cur != $past(r_cur))
        else $error("accepted sample did not advance the mux");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty input register");

endmodule : mux_sensor_hysteresis_scanner_unit
`default_nettype wire

// ===== tb/sv/mux_sensor_hysteresis_scanner_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mux_sensor_hysteresis_scanner_unit_test
// self-checking bench for the multiplexed light-sensor scanner
// ----------------------------------------------------------------------------
// Request beats go in through a valid/stall channel with random gaps. Each
// accepted beat runs through a local scanner model that keeps its own channel
// tables, mux pointer, scan counter and rate latch. The predicted result is
// queued and compared with the next result beat, which the sink takes under
// random stall. Directed tests cover reset state, hysteresis edges, mux wrap,
// threshold clamping, disabled scanning, short and long rate windows.
// A random mix over several scan_enable settings and idle patterns follows.
// ----------------------------------------------------------------------------
module mux_sensor_hysteresis_scanner_unit_test;

    localparam int NUM_CH = 8;
    // worst run is far below this, even with every gap and stall at maximum
    localparam longint unsigned RUN_LIMIT_NS = 64'd15_000_000;

    // one result beat as seen on the output ports
    typedef struct packed {
        logic        accepted;
        logic [2:0]  chan;
        logic        is_light;
        logic [11:0] raw;
        logic [2:0]  mux_address;
        logic [15:0] high_thr;
        logic [15:0] low_thr;
        logic [22:0] scan_rate;
    } t_scan_result;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n;
    always #6 i_clk = ~i_clk;

    // block ports
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_req_type;
    logic [11:0] i_sample_value;
    logic [2:0]  i_target_channel;
    logic [15:0] i_threshold_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_accepted;
    logic [2:0]  o_channel_out;
    logic        o_is_light;
    logic [11:0] o_raw_out;
    logic [2:0]  o_mux_address;
    logic [15:0] o_high_out;
    logic [15:0] o_low_out;
    logic [22:0] o_scan_rate;

    // idle switches, flipped per test so that some stretches run back to back
    logic send_idle = 1'b0;
    logic sink_idle = 1'b0;

    // scanner model state
    logic              scan_en_m;
    logic [2:0]        cur_ch_m;
    logic              light_m [NUM_CH];
    logic [11:0]       raw_m   [NUM_CH];
    logic [15:0]       high_m  [NUM_CH];
    logic [15:0]       low_m   [NUM_CH];
    logic [15:0]       count_m;
    logic [22:0]       rate_m;

    // results predicted but not yet seen
    t_scan_result pending_results [$];
    int unsigned  mismatch_count = 0;

    mux_sensor_hysteresis_scanner_unit #(
        .CHANNELS(NUM_CH)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_sample_value    (i_sample_value),
        .i_target_channel  (i_target_channel),
        .i_threshold_value (i_threshold_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_accepted        (o_accepted),
        .o_channel_out     (o_channel_out),
        .o_is_light        (o_is_light),
        .o_raw_out         (o_raw_out),
        .o_mux_address     (o_mux_address),
        .o_high_out        (o_high_out),
        .o_low_out         (o_low_out),
        .o_scan_rate       (o_scan_rate)
    );

    // ------------------------------------------------------------------
    // scanner model
    // ------------------------------------------------------------------

    // state after reset
    task automatic reset_scanner_model();
        scan_en_m = 1'b1;
        cur_ch_m  = '0;
        count_m   = '0;
        rate_m    = '0;
        for (int i = 0; i < NUM_CH; i++) begin
            light_m[i] = 1'b0;
            raw_m[i]   = '0;
            high_m[i]  = mshs_pkg::DEFAULT_HIGH;
            low_m[i]   = mshs_pkg::DEFAULT_LOW;
        end
    endtask

    // view of one channel after the step; out-of-range channels read as zero
    function automatic t_scan_result channel_view(input logic acc, input logic [2:0] ch,
                                                  input logic in_range);
        t_scan_result r;
        r.accepted    = acc;
        r.chan        = ch;
        r.is_light    = in_range ? light_m[ch] : 1'b0;
        r.raw         = in_range ? raw_m[ch]   : 12'd0;
        r.high_thr    = in_range ? high_m[ch]  : 16'd0;
        r.low_thr     = in_range ? low_m[ch]   : 16'd0;
        r.mux_address = cur_ch_m;
        r.scan_rate   = rate_m;
        return r;
    endfunction

    // apply one accepted request to the model and queue its result
    task automatic predict_scan_result(input mshs_pkg::t_req req, input logic [11:0] smp,
                                       input logic [2:0] tch, input logic [15:0] thr);
        t_scan_result res;
        logic [2:0]   ch;
        int unsigned  quot;
        ch = cur_ch_m;
        unique case (req)
            mshs_pkg::REQ_SAMPLE: begin
                if (!scan_en_m) begin
                    // ignored, reports the channel on the mux
                    res = channel_view(1'b0, ch, 1'b1);
                end else begin
                    raw_m[ch] = smp;
                    // sticky flag: set at or above high, cleared at or below low
                    if ({4'd0, smp} >= high_m[ch]) begin
                        light_m[ch] = 1'b1;
                    end else if ({4'd0, smp} <= low_m[ch]) begin
                        light_m[ch] = 1'b0;
                    end
                    cur_ch_m = (int'(ch) + 1 >= NUM_CH) ? 3'd0 : ch + 3'd1;
                    if (count_m != mshs_pkg::COUNT_MAX) begin
                        count_m = count_m + 16'd1;
                    end
                    res = channel_view(1'b1, ch, 1'b1);
                end
            end
            mshs_pkg::REQ_TICK: begin
                quot    = (32'(count_m) * mshs_pkg::RATE_SCALE) / NUM_CH;
                rate_m  = (quot > mshs_pkg::RATE_MAX) ? mshs_pkg::RATE_MAX : quot[22:0];
                count_m = '0;
                res     = channel_view(1'b1, cur_ch_m, 1'b1);
            end
            default: begin
                if (int'(tch) >= NUM_CH) begin
                    res = channel_view(1'b0, tch, 1'b0);
                end else begin
                    if (req == mshs_pkg::REQ_WR_HIGH) begin
                        // high must stay above low
                        if (thr > low_m[tch]) begin
                            high_m[tch] = thr;
                        end else if (low_m[tch] != mshs_pkg::THR_MAX) begin
                            high_m[tch] = low_m[tch] + 16'd1;
                        end
                    end else begin
                        // low must stay below high
                        if (thr < high_m[tch]) begin
                            low_m[tch] = thr;
                        end else if (high_m[tch] != 16'd0) begin
                            low_m[tch] = high_m[tch] - 16'd1;
                        end
                    end
                    res = channel_view(1'b1, tch, 1'b1);
                end
            end
        endcase
        pending_results.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // one request beat: optional gap, then hold until taken
    task automatic send_request(input mshs_pkg::t_req req, input logic [11:0] smp,
                                input logic [2:0] tch, input logic [15:0] thr);
        int unsigned gap;
        gap = send_idle ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_req_type        <= req;
        i_sample_value    <= smp;
        i_target_channel  <= tch;
        i_threshold_value <= thr;
        // payload stays put while stalled
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_scan_result(req, smp, tch, thr);
    endtask

    // stop sending and let every predicted beat come out
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register write, only with the block idle
    task automatic write_scan_enable(input logic en);
        wait_results_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= en;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        scan_en_m = en;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // sink stall: per beat hold stall for a random count, then take a beat
    initial begin : sink_stall_gen
        int unsigned hold;
        forever begin
            hold = sink_idle ? $urandom_range(0, 16) : 0;
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && i_out_stall === 1'b0));
        end
    end

    // compare every taken result beat with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_scan_result got;
        t_scan_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            got.accepted    = o_accepted;
            got.chan        = o_channel_out;
            got.is_light    = o_is_light;
            got.raw         = o_raw_out;
            got.mux_address = o_mux_address;
            got.high_thr    = o_high_out;
            got.low_thr     = o_low_out;
            got.scan_rate   = o_scan_rate;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: result beat with nothing predicted: acc=%0d ch=%0d",
                             $time, got.accepted, got.chan);
                end
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: want acc=%0d ch=%0d light=%0d raw=%0d mux=%0d",
                                 $time, want.accepted, want.chan, want.is_light,
                                 want.raw, want.mux_address);
                        $display("%0t: want hi=%0d lo=%0d rate=%0d",
                                 $time, want.high_thr, want.low_thr, want.scan_rate);
                        $display("%0t: got  acc=%0d ch=%0d light=%0d raw=%0d mux=%0d",
                                 $time, got.accepted, got.chan, got.is_light,
                                 got.raw, got.mux_address);
                        $display("%0t: got  hi=%0d lo=%0d rate=%0d",
                                 $time, got.high_thr, got.low_thr, got.scan_rate);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // a tick right after reset shows the default tables of channel 0
    task automatic test_reset_state();
        send_request(mshs_pkg::REQ_TICK, 12'hFFF, 3'd7, 16'hFFFF);
    endtask

    // two laps over all channels: edges of both thresholds, sticky middle band
    task automatic test_sample_hysteresis();
        logic [11:0] first_lap  [NUM_CH];
        logic [11:0] second_lap [NUM_CH];
        first_lap  = '{12'd999, 12'd1000, 12'd4095, 12'd401,
                       12'd0,   12'd1001, 12'd700,  12'd1500};
        second_lap = '{12'd0,   12'd401,  12'd400,  12'd999,
                       12'd1000, 12'd700, 12'd4095, 12'd0};
        send_idle = 1'b1;
        sink_idle = 1'b1;
        for (int i = 0; i < NUM_CH; i++) begin
            send_request(mshs_pkg::REQ_SAMPLE, first_lap[i], 3'($urandom), 16'($urandom));
        end
        // mux wraps back to channel 0 here
        for (int i = 0; i < NUM_CH; i++) begin
            send_request(mshs_pkg::REQ_SAMPLE, second_lap[i], 3'($urandom), 16'($urandom));
        end
    endtask

    // clamp rules of both threshold writes, with the 16-bit extremes
    task automatic test_threshold_clamp();
        send_idle = 1'b0;
        sink_idle = 1'b1;
        send_request(mshs_pkg::REQ_WR_HIGH, 12'd0, 3'd3, 16'd0);       // not above low
        send_request(mshs_pkg::REQ_WR_LOW,  12'd0, 3'd3, 16'hFFFF);    // not below high
        send_request(mshs_pkg::REQ_WR_HIGH, 12'd0, 3'd3, 16'hFFFF);
        send_request(mshs_pkg::REQ_WR_LOW,  12'd0, 3'd3, 16'hFFFF);    // clamps to high-1
        send_request(mshs_pkg::REQ_WR_LOW,  12'd0, 3'd3, 16'd0);
        send_request(mshs_pkg::REQ_WR_HIGH, 12'd0, 3'd5, 16'd400);     // equal to low
        send_request(mshs_pkg::REQ_WR_HIGH, 12'd0, 3'd3, mshs_pkg::DEFAULT_HIGH);
        send_request(mshs_pkg::REQ_WR_LOW,  12'd0, 3'd3, mshs_pkg::DEFAULT_LOW);
    endtask

    // with scanning off samples are dropped, ticks and writes still apply
    task automatic test_scan_disable();
        send_idle = 1'b1;
        sink_idle = 1'b0;
        write_scan_enable(1'b0);
        send_request(mshs_pkg::REQ_SAMPLE,  12'd4095, 3'd0, 16'd0);
        send_request(mshs_pkg::REQ_SAMPLE,  12'd0,    3'd0, 16'd0);
        send_request(mshs_pkg::REQ_WR_LOW,  12'd0,    3'd7, 16'd123);
        send_request(mshs_pkg::REQ_TICK,    12'd0,    3'd0, 16'd0);
        write_scan_enable(1'b1);
    endtask

    // rate window: a few samples, then a tick latches count*1000/channels
    task automatic test_rate_window();
        send_idle = 1'b0;
        sink_idle = 1'b0;
        repeat (3) begin
            send_request(mshs_pkg::REQ_SAMPLE, 12'($urandom), 3'($urandom), 16'($urandom));
        end
        send_request(mshs_pkg::REQ_TICK, 12'd0, 3'd0, 16'd0);
    endtask

    // clearing tick, a long rate window of 101 samples, then two ticks
    task automatic test_long_window();
        send_idle = 1'b0;
        sink_idle = 1'b0;
        send_request(mshs_pkg::REQ_TICK, 12'd0, 3'd0, 16'd0);
        repeat (101) begin
            send_request(mshs_pkg::REQ_SAMPLE, 12'($urandom), 3'($urandom), 16'($urandom));
        end
        send_request(mshs_pkg::REQ_TICK, 12'd0, 3'd0, 16'd0);
        send_request(mshs_pkg::REQ_TICK, 12'd0, 3'd0, 16'd0);
    endtask

    // random mix, samples weighted toward the current channel's thresholds
    task automatic test_random_mix(input int unsigned n_items);
        int unsigned    pick;
        logic [31:0]    rnd;
        int             near;
        mshs_pkg::t_req req;
        logic [11:0]    smp;
        logic [15:0]    thr;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                req = mshs_pkg::REQ_SAMPLE;
            end else if (pick < 70) begin
                req = mshs_pkg::REQ_TICK;
            end else if (pick < 85) begin
                req = mshs_pkg::REQ_WR_HIGH;
            end else begin
                req = mshs_pkg::REQ_WR_LOW;
            end
            rnd = $urandom;
            smp = rnd[11:0];
            if ($urandom_range(0, 2) != 0) begin
                near = ($urandom_range(0, 1) != 0) ? int'(high_m[cur_ch_m])
                                                   : int'(low_m[cur_ch_m]);
                near = near + int'($urandom_range(0, 6)) - 3;
                if (near < 0) near = 0;
                if (near > 4095) near = 4095;
                smp = near[11:0];
            end
            // thresholds mostly inside the adc range so flags keep moving
            rnd = $urandom;
            thr = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 4095)) : rnd[15:0];
            send_request(req, smp, 3'($urandom), thr);
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= 1'b0;
        i_in_valid        <= 1'b0;
        i_req_type        <= mshs_pkg::REQ_SAMPLE;
        i_sample_value    <= '0;
        i_target_channel  <= '0;
        i_threshold_value <= '0;
        reset_scanner_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_sample_hysteresis();
        test_threshold_clamp();
        test_scan_disable();
        test_rate_window();
        test_long_window();

        // random phases over enable settings and idle patterns
        write_scan_enable(1'b1);
        send_idle = 1'b1;
        sink_idle = 1'b1;
        test_random_mix(300);
        write_scan_enable(1'b0);
        send_idle = 1'b1;
        sink_idle = 1'b0;
        test_random_mix(100);
        write_scan_enable(1'b1);
        send_idle = 1'b0;
        sink_idle = 1'b1;
        test_random_mix(250);
        write_scan_enable(1'b1);
        send_idle = 1'b1;
        sink_idle = 1'b0;
        test_random_mix(180);
        wait_results_drained();
        send_idle = 1'b0;
        sink_idle = 1'b0;
        test_random_mix(120);

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("mux_sensor_hysteresis_scanner_unit_test: PASS");
        end else begin
            $display("mux_sensor_hysteresis_scanner_unit_test: FAIL");
        end
        $finish;
    end

    // watchdog on the whole run
    initial begin
        #(RUN_LIMIT_NS);
        $display("mux_sensor_hysteresis_scanner_unit_test: FAIL");
        $finish;
    end

endmodule
